FILE: rtl/core/fptg_pkg.sv
// ----------------------------------------------------------------------------
// fptg_pkg
// Shared types, constants and elaboration-time tables for the focal point
// trajectory generator.
// ----------------------------------------------------------------------------
package fptg_pkg;

  localparam int SAMPLES    = 200;
  localparam int TRIG_STEPS = 4096;
  localparam int COORD_BITS = 16;
  localparam int QTR        = TRIG_STEPS / 4;
  localparam int QTR_W      = $clog2(QTR);
  localparam int K_W        = $clog2(TRIG_STEPS);
  localparam int IDX_W      = 8;
  localparam int TRIG_W     = 15;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // request kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // modes
  localparam logic [2:0] MODE_POINT   = 3'd0;
  localparam logic [2:0] MODE_POLYGON = 3'd1;
  localparam logic [2:0] MODE_LINEAR  = 3'd2;
  localparam logic [2:0] MODE_INDEXED = 3'd3;
  localparam logic [2:0] MODE_CIRCLE  = 3'd4;
  localparam logic [2:0] MODE_TWIN    = 3'd5;

  // register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_SEGS    = 3'd1;
  localparam logic [2:0] REG_CENTER  = 3'd2;
  localparam logic [2:0] REG_START   = 3'd3;
  localparam logic [2:0] REG_END     = 3'd4;
  localparam logic [2:0] REG_RADIUS  = 3'd5;
  localparam logic [2:0] REG_BASIS_U = 3'd6;
  localparam logic [2:0] REG_BASIS_V = 3'd7;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] val;
  } item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  seg;
    logic [47:0] center_pos;
    logic [47:0] start_pos;
    logic [47:0] end_pos;
    logic [15:0] radius;
    logic [47:0] basis_u;
    logic [47:0] basis_v;
  } cfg_t;

  typedef logic [TRIG_W-1:0] trig_tab_t [QTR];
  typedef logic [31:0] recip_tab_t [256];

  // shift-subtract quotient of non-negative operands
  function automatic longint udiv(input longint num, input longint den);
    longint q;
    longint rem;
    q = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        q = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  function automatic longint taylor_q14(input longint y, input bit is_cos);
    longint y2;
    longint t;
    longint n;
    longint sum;
    y2 = (y * y) >>> 30;
    t = is_cos ? (64'sd1 <<< 30) : y;
    n = is_cos ? 64'sd0 : 64'sd1;
    sum = t;
    for (int s = 0; s < 8; s++) begin
      t = udiv((t * y2) >>> 30, (n + 1) * (n + 2));
      n = n + 2;
      sum = (s % 2 == 1) ? sum + t : sum - t;
    end
    if (sum < 0) begin
      sum = 0;
    end
    return (sum + (64'sd1 <<< 15)) >>> 16;
  endfunction

  function automatic trig_tab_t build_trig(input bit is_cos);
    trig_tab_t tab;
    longint    y;
    for (int j = 0; j < QTR; j++) begin
      y = (longint'(j) * HALF_PI_Q30) / QTR;
      tab[j] = TRIG_W'(taylor_q14(y, is_cos));
    end
    return tab;
  endfunction

  // ceil(2^32 / (2*d)) for polygon vertex angle
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    longint     d2;
    tab[0] = '0;
    for (int d = 1; d < 256; d++) begin
      d2 = 2 * longint'(d);
      tab[d] = 32'(udiv((64'sd1 <<< 32) + d2 - 1, d2));
    end
    return tab;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7fff;
    end else if (v < -24'sd32768) begin
      return 16'sh8000;
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/fptg_front.sv
// ----------------------------------------------------------------------------
// fptg_front
// Accepts requests, drops those that give nothing, and hands the rest to the
// queue through one register stage.
// ----------------------------------------------------------------------------
module fptg_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [7:0]           in_sample_index,
  input  logic [7:0]           in_order_value,
  input  logic                 in_suppress,
  input  logic [2:0]           mode,
  input  logic                 q_full,
  output logic                 q_push,
  output fptg_pkg::item_t      q_item
);
  import fptg_pkg::*;

  logic  f_vld_r;
  logic  f_keep_r;
  item_t f_item_r;
  logic  f_go;
  logic  keep;
  logic  idx_ok;

  assign idx_ok   = in_sample_index < IDX_W'(SAMPLES);
  assign keep     = in_req_type ? idx_ok
                                : (!in_suppress && idx_ok && mode <= MODE_TWIN);
  assign f_go     = f_vld_r && (!f_keep_r || !q_full);
  assign in_ready = !f_vld_r || f_go;
  assign q_push   = f_vld_r && f_keep_r && !q_full;
  assign q_item   = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_vld_r <= 1'b1;
    end else if (f_go) begin
      f_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_keep_r     <= keep;
      f_item_r.op  <= in_req_type;
      f_item_r.idx <= in_sample_index;
      f_item_r.val <= in_order_value;
    end
  end

endmodule

FILE: rtl/core/fptg_queue.sv
// ----------------------------------------------------------------------------
// fptg_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module fptg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fptg_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output fptg_pkg::item_t head
);
  import fptg_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r;
  logic [Q_PTR_W-1:0] rd_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;

  assign full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue overflow");
  a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue push count");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 1'b1) else $error("queue pop count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/fptg_back.sv
// ----------------------------------------------------------------------------
// fptg_back
// Execution pipeline: order table, index arithmetic, trig ROM, ring and line
// datapaths, output register.
// ----------------------------------------------------------------------------
module fptg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fptg_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  input  fptg_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           out_focus_x,
  output logic signed [15:0]           out_focus_y,
  output logic signed [15:0]           out_focus_z,
  output logic                         out_twin_trap
);
  import fptg_pkg::*;

  localparam trig_tab_t  SIN_TAB   = build_trig(1'b0);
  localparam trig_tab_t  COS_TAB   = build_trig(1'b1);
  localparam recip_tab_t RECIP_TAB = build_recip();
  localparam logic [16:0] R200     = 17'(((1 << 24) + SAMPLES - 1) / SAMPLES);
  localparam logic [21:0] R400     = 22'(((1 << 30) + 2 * SAMPLES - 1) / (2 * SAMPLES));
  localparam logic [27:0] R36      = 28'(((64'sd1 <<< 36) + 2 * SAMPLES - 1) / (2 * SAMPLES));
  localparam logic [26:0] LBIAS    = 27'(2 * SAMPLES * (1 << 17) + SAMPLES);
  localparam int          NSTG     = 8;

  logic             en;
  logic [7:0]       seg_c;
  logic [NSTG-1:0]  res_r;
  logic [7:0]       order_mem [SAMPLES];

  // stage A
  logic [15:0] a_p_r;
  logic [20:0] a_nc_r;
  logic [7:0]  a_tab_r;
  // stage B
  logic [7:0]  b_s_r;
  logic [15:0] b_p_r;
  logic [11:0] b_kc_r;
  logic [31:0] b_recip_r;
  logic [7:0]  b_tab_r;
  logic [32:0] b_sprod;
  logic [42:0] b_kprod;
  // stage C
  logic [7:0]  c_n_r;
  logic        c_dir_r;
  logic [20:0] c_np_r;
  logic [31:0] c_recip_r;
  logic [11:0] c_kc_r;
  logic [7:0]  c_tab_r;
  logic [15:0] c_sm;
  // stage D
  logic [52:0]        d_kprod;
  logic [K_W-1:0]     d_k_r;
  logic [7:0]         d_n_r;
  logic signed [15:0] d_a_r    [3];
  logic signed [16:0] d_diff_r [3];
  // stage E
  logic [TRIG_W-1:0]  e_sin_r;
  logic [TRIG_W-1:0]  e_cos_r;
  logic [1:0]         e_q_r;
  logic signed [25:0] e_prod_r [3];
  logic signed [15:0] e_a_r    [3];
  // stage F
  logic signed [15:0] f_c;
  logic signed [15:0] f_s;
  logic signed [31:0] f_cu_r   [3];
  logic signed [31:0] f_sv_r   [3];
  logic signed [18:0] f_q_r    [3];
  logic signed [15:0] f_a_r    [3];
  logic [26:0]        f_xb     [3];
  logic [54:0]        f_qprod  [3];
  // stage G
  logic signed [31:0] g_acc_r  [3];
  logic signed [15:0] g_lin_r  [3];
  // stage H
  logic signed [48:0] h_prod_r [3];
  logic signed [15:0] h_lin_r  [3];
  // output
  logic signed [15:0] o_pos    [3];
  logic signed [20:0] o_off    [3];
  logic signed [15:0] o_ctr    [3];
  logic               o_vld_r;
  logic signed [15:0] o_x_r;
  logic signed [15:0] o_y_r;
  logic signed [15:0] o_z_r;
  logic               o_twin_r;

  assign en    = !o_vld_r || out_ready;
  assign q_pop = en && q_valid;
  assign seg_c = (cfg.seg == 8'd0) ? 8'd1 :
                 (cfg.seg > 8'(SAMPLES)) ? 8'(SAMPLES) : cfg.seg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r   <= '0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      res_r   <= {res_r[NSTG-2:0], q_valid && q_item.op == OP_TICK};
      o_vld_r <= res_r[NSTG-1];
    end
  end

  // order table
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_WRITE) begin
      order_mem[q_item.idx] <= q_item.val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tab_r <= order_mem[q_item.idx];
      a_p_r   <= q_item.idx * seg_c;
      a_nc_r  <= {q_item.idx, 13'd0} + 21'(SAMPLES);
    end
  end

  assign b_sprod = a_p_r * R200;
  assign b_kprod = a_nc_r * R400;

  always_ff @(posedge clk) begin
    if (en) begin
      b_s_r     <= b_sprod[31:24];
      b_p_r     <= a_p_r;
      b_kc_r    <= b_kprod[41:30];
      b_recip_r <= RECIP_TAB[seg_c];
      b_tab_r   <= a_tab_r;
    end
  end

  assign c_sm = b_s_r * 8'(SAMPLES);

  always_ff @(posedge clk) begin
    if (en) begin
      c_n_r     <= 8'(b_p_r - c_sm);
      c_dir_r   <= b_s_r[0];
      c_np_r    <= {b_s_r, 13'd0} + 21'(seg_c);
      c_recip_r <= b_recip_r;
      c_kc_r    <= b_kc_r;
      c_tab_r   <= b_tab_r;
    end
  end

  assign d_kprod = c_np_r * c_recip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_k_r <= (cfg.mode == MODE_POLYGON) ? d_kprod[32 +: K_W] : c_kc_r;
      d_n_r <= (cfg.mode == MODE_INDEXED) ? c_tab_r : c_n_r;
      for (int j = 0; j < 3; j++) begin
        if (cfg.mode == MODE_LINEAR && c_dir_r) begin
          d_a_r[j]    <= cfg.end_pos[16*j +: 16];
          d_diff_r[j] <= 17'(signed'(cfg.start_pos[16*j +: 16]))
                       - 17'(signed'(cfg.end_pos[16*j +: 16]));
        end else begin
          d_a_r[j]    <= cfg.start_pos[16*j +: 16];
          d_diff_r[j] <= 17'(signed'(cfg.end_pos[16*j +: 16]))
                       - 17'(signed'(cfg.start_pos[16*j +: 16]));
        end
      end
    end
  end

  // trig ROM, quarter wave
  always_ff @(posedge clk) begin
    if (en) begin
      e_sin_r <= SIN_TAB[d_k_r[QTR_W-1:0]];
      e_cos_r <= COS_TAB[d_k_r[QTR_W-1:0]];
      e_q_r   <= d_k_r[K_W-1 -: 2];
      for (int j = 0; j < 3; j++) begin
        e_prod_r[j] <= 26'(d_diff_r[j]) * 26'(signed'({1'b0, d_n_r}));
        e_a_r[j]    <= d_a_r[j];
      end
    end
  end

  always_comb begin
    case (e_q_r)
      2'd0: begin
        f_c = 16'(e_cos_r);
        f_s = 16'(e_sin_r);
      end
      2'd1: begin
        f_c = -16'(e_sin_r);
        f_s = 16'(e_cos_r);
      end
      2'd2: begin
        f_c = -16'(e_cos_r);
        f_s = -16'(e_sin_r);
      end
      default: begin
        f_c = 16'(e_sin_r);
        f_s = -16'(e_cos_r);
      end
    endcase
    for (int j = 0; j < 3; j++) begin
      f_xb[j]    = 27'(signed'({e_prod_r[j], 1'b0})) + LBIAS;
      f_qprod[j] = f_xb[j] * R36;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        f_cu_r[j] <= f_c * signed'(cfg.basis_u[16*j +: 16]);
        f_sv_r[j] <= f_s * signed'(cfg.basis_v[16*j +: 16]);
        f_q_r[j]  <= signed'(f_qprod[j][54:36]) - 19'sd131072;
        f_a_r[j]  <= e_a_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        g_acc_r[j] <= f_cu_r[j] + f_sv_r[j];
        g_lin_r[j] <= sat_coord(24'(f_a_r[j]) + 24'(f_q_r[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        h_prod_r[j] <= 49'(g_acc_r[j]) * 49'(signed'({1'b0, cfg.radius}));
        h_lin_r[j]  <= g_lin_r[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      o_ctr[j] = cfg.center_pos[16*j +: 16];
      o_off[j] = 21'((h_prod_r[j] + 49'sd134217728) >>> 28);
      case (cfg.mode)
        MODE_POLYGON, MODE_CIRCLE: o_pos[j] = sat_coord(24'(o_ctr[j]) + 24'(o_off[j]));
        MODE_LINEAR, MODE_INDEXED: o_pos[j] = h_lin_r[j];
        default:                   o_pos[j] = o_ctr[j];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_x_r    <= o_pos[0];
      o_y_r    <= o_pos[1];
      o_z_r    <= o_pos[2];
      o_twin_r <= cfg.mode == MODE_TWIN;
    end
  end

  assign out_valid     = o_vld_r;
  assign out_focus_x   = o_x_r;
  assign out_focus_y   = o_y_r;
  assign out_focus_z   = o_z_r;
  assign out_twin_trap = o_twin_r;

`ifndef SYNTHESIS
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> res_r == $past(res_r)) else $error("pipeline moved while stalled");
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> en) else $error("pop while output stalled");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    en && res_r[NSTG-1] |=> o_vld_r) else $error("result lost at output");
`endif

endmodule

FILE: rtl/core/focal_point_trajectory_generator.sv
// ----------------------------------------------------------------------------
// focal_point_trajectory_generator
// Turns sample ticks into 3-D focus positions; also takes order table writes.
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  input    | in_valid / in_ready            | one request: tick or table write
//  output   | out_valid / out_ready          | one focus position
//  config   | psel penable pwrite paddr ...  | register writes and reads
//
//  One request per cycle while the queue has room and the output is not held.
//  The back pipeline is 8 stages plus the output register, fed by a 4-deep
//  queue; it freezes as a whole while the output register is held.
//  Synchronous active-low reset; the order table is not cleared.
// ----------------------------------------------------------------------------
module focal_point_trajectory_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [7:0]         in_sample_index,
  input  logic [7:0]         in_order_value,
  input  logic               in_suppress,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_focus_x,
  output logic signed [15:0] out_focus_y,
  output logic signed [15:0] out_focus_z,
  output logic               out_twin_trap,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import fptg_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_sel;
  logic       q_full;
  logic       q_push;
  item_t      q_in;
  logic       q_pop;
  logic       q_valid;
  item_t      q_head;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: '0, seg: 8'd1, center_pos: '0, start_pos: '0, end_pos: '0,
                 radius: '0, basis_u: '0, basis_v: '0};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_MODE:    cfg_r.mode       <= pwdata[2:0];
        REG_SEGS:    cfg_r.seg        <= pwdata[7:0];
        REG_CENTER:  cfg_r.center_pos <= pwdata[47:0];
        REG_START:   cfg_r.start_pos  <= pwdata[47:0];
        REG_END:     cfg_r.end_pos    <= pwdata[47:0];
        REG_RADIUS:  cfg_r.radius     <= pwdata[15:0];
        REG_BASIS_U: cfg_r.basis_u    <= pwdata[47:0];
        REG_BASIS_V: cfg_r.basis_v    <= pwdata[47:0];
        default:     cfg_r            <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:    prdata = 64'(cfg_r.mode);
      REG_SEGS:    prdata = 64'(cfg_r.seg);
      REG_CENTER:  prdata = 64'(cfg_r.center_pos);
      REG_START:   prdata = 64'(cfg_r.start_pos);
      REG_END:     prdata = 64'(cfg_r.end_pos);
      REG_RADIUS:  prdata = 64'(cfg_r.radius);
      REG_BASIS_U: prdata = 64'(cfg_r.basis_u);
      REG_BASIS_V: prdata = 64'(cfg_r.basis_v);
      default:     prdata = '0;
    endcase
  end

  fptg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_sample_index (in_sample_index),
    .in_order_value  (in_order_value),
    .in_suppress     (in_suppress),
    .mode            (cfg_r.mode),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_in)
  );

  fptg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  fptg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_focus_x   (out_focus_x),
    .out_focus_y   (out_focus_y),
    .out_focus_z   (out_focus_z),
    .out_twin_trap (out_twin_trap)
  );

endmodule
